/* hw/rtl/ltc_pkg.sv */
`timescale 1ns / 1ps

package ltc_pkg;

    // Kind of the first character of a token
    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_QUOTE = 3'd1,
        KIND_BRACE = 3'd2,
        KIND_MINUS = 3'd3,
        KIND_ALPHA = 3'd4
    } char_kind_t;

    // Literal class codes on the result port
    typedef enum logic [2:0] {
        CLS_INVALID = 3'd0,
        CLS_INT     = 3'd1,
        CLS_FLOAT   = 3'd2,
        CLS_DOUBLE  = 3'd3,
        CLS_BOOL    = 3'd4,
        CLS_STRING  = 3'd5,
        CLS_STRUCT  = 3'd6,
        CLS_IDENT   = 3'd7
    } token_class_t;

    // One accepted character word
    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } char_word_t;

    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_UPPER_F    = 8'h46;

    localparam logic [2:0] POS_MAX        = 3'd7;
    localparam logic [2:0] TRUE_LAST_POS  = 3'd3;
    localparam logic [2:0] FALSE_LAST_POS = 3'd4;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic char_kind_t kind_of(input logic [7:0] c);
        char_kind_t k;
        priority if (c == CH_QUOTE) k = KIND_QUOTE;
        else if (c == CH_LBRACE) k = KIND_BRACE;
        else if (c == CH_MINUS) k = KIND_MINUS;
        else if (is_alpha(c) || (c == CH_UNDERSCORE)) k = KIND_ALPHA;
        else k = KIND_OTHER;
        return k;
    endfunction

    // Letters of "true" by position
    function automatic logic [7:0] true_char(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0: ch = 8'h74;
            2'd1: ch = 8'h72;
            2'd2: ch = 8'h75;
            2'd3: ch = 8'h65;
        endcase
        return ch;
    endfunction

    // Letters of "false" by position; positions past the word never match
    function automatic logic [7:0] false_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h66;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h6C;
            3'd3:    ch = 8'h73;
            3'd4:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* hw/rtl/ltc_scan.sv */
`timescale 1ns / 1ps

module ltc_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  ltc_pkg::char_word_t   word,
    output ltc_pkg::token_class_t token_class
);

    logic [2:0]          char_position_reg, char_position_next;
    ltc_pkg::char_kind_t first_char_kind_reg, first_char_kind_next;
    logic                seen_dot_reg, seen_dot_next;
    logic                numeric_ok_reg, numeric_ok_next;
    logic                ident_ok_reg, ident_ok_next;
    logic                true_match_reg, true_match_next;
    logic                false_match_reg, false_match_next;

    logic                first;
    logic [7:0]          c;
    ltc_pkg::char_kind_t fk;
    logic                num, dot, is_float, id, tm, fm;

    assign c     = word.char_byte;
    assign first = (char_position_reg == 3'd0);
    assign fk    = first ? ltc_pkg::kind_of(c) : first_char_kind_reg;

    always_comb
    begin
        num      = numeric_ok_reg;
        dot      = seen_dot_reg;
        is_float = 1'b0;
        priority if (first && (c == ltc_pkg::CH_MINUS))
        begin
            num = numeric_ok_reg;
        end
        else if (c == ltc_pkg::CH_DOT)
        begin
            if (seen_dot_reg)
                num = 1'b0;
            else
                dot = 1'b1;
        end
        else if (ltc_pkg::is_digit(c))
        begin
            num = numeric_ok_reg;
        end
        else if (word.last_char && seen_dot_reg
                 && ((c == ltc_pkg::CH_LOWER_F) || (c == ltc_pkg::CH_UPPER_F)))
        begin
            is_float = 1'b1;
        end
        else
        begin
            num = 1'b0;
        end
    end

    always_comb
    begin
        id = ident_ok_reg;
        if (first)
        begin
            if (!(ltc_pkg::is_alpha(c) || (c == ltc_pkg::CH_UNDERSCORE)))
                id = 1'b0;
        end
        else if (!(ltc_pkg::is_alpha(c) || ltc_pkg::is_digit(c)
                   || (c == ltc_pkg::CH_UNDERSCORE)))
        begin
            id = 1'b0;
        end
    end

    assign tm = true_match_reg && (char_position_reg < 3'd4)
                && (c == ltc_pkg::true_char(char_position_reg[1:0]));
    assign fm = false_match_reg && (char_position_reg < 3'd5)
                && (c == ltc_pkg::false_char(char_position_reg));

    always_comb
    begin
        priority if ((char_position_reg != 3'd0) && (fk == ltc_pkg::KIND_QUOTE)
                     && (c == ltc_pkg::CH_QUOTE))
            token_class = ltc_pkg::CLS_STRING;
        else if ((tm && (char_position_reg == ltc_pkg::TRUE_LAST_POS))
                 || (fm && (char_position_reg == ltc_pkg::FALSE_LAST_POS)))
            token_class = ltc_pkg::CLS_BOOL;
        else if (fk == ltc_pkg::KIND_BRACE)
            token_class = ltc_pkg::CLS_STRUCT;
        else if (num)
            token_class = dot ? (is_float ? ltc_pkg::CLS_FLOAT : ltc_pkg::CLS_DOUBLE)
                              : ltc_pkg::CLS_INT;
        else if (id)
            token_class = ltc_pkg::CLS_IDENT;
        else
            token_class = ltc_pkg::CLS_INVALID;
    end

    always_comb
    begin
        char_position_next   = char_position_reg;
        first_char_kind_next = first_char_kind_reg;
        seen_dot_next        = seen_dot_reg;
        numeric_ok_next      = numeric_ok_reg;
        ident_ok_next        = ident_ok_reg;
        true_match_next      = true_match_reg;
        false_match_next     = false_match_reg;
        if (fire)
        begin
            if (word.last_char)
            begin
                // drop all token state for the next token
                char_position_next   = 3'd0;
                first_char_kind_next = ltc_pkg::KIND_OTHER;
                seen_dot_next        = 1'b0;
                numeric_ok_next      = 1'b1;
                ident_ok_next        = 1'b1;
                true_match_next      = 1'b1;
                false_match_next     = 1'b1;
            end
            else
            begin
                char_position_next   = (char_position_reg == ltc_pkg::POS_MAX)
                                       ? ltc_pkg::POS_MAX : char_position_reg + 3'd1;
                first_char_kind_next = fk;
                seen_dot_next        = dot;
                numeric_ok_next      = num;
                ident_ok_next        = id;
                true_match_next      = tm;
                false_match_next     = fm;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_position_reg   <= 3'd0;
            first_char_kind_reg <= ltc_pkg::KIND_OTHER;
            seen_dot_reg        <= 1'b0;
            numeric_ok_reg      <= 1'b1;
            ident_ok_reg        <= 1'b1;
            true_match_reg      <= 1'b1;
            false_match_reg     <= 1'b1;
        end
        else
        begin
            char_position_reg   <= char_position_next;
            first_char_kind_reg <= first_char_kind_next;
            seen_dot_reg        <= seen_dot_next;
            numeric_ok_reg      <= numeric_ok_next;
            ident_ok_reg        <= ident_ok_next;
            true_match_reg      <= true_match_next;
            false_match_reg     <= false_match_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !word.last_char && (char_position_reg != ltc_pkg::POS_MAX)
        |=> char_position_reg == $past(char_position_reg) + 3'd1)
        else $error("character position did not advance");

    a_token_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && word.last_char
        |=> (char_position_reg == 3'd0) && numeric_ok_reg && ident_ok_reg
            && true_match_reg && false_match_reg && !seen_dot_reg)
        else $error("token state not cleared after last character");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(char_position_reg) && $stable(seen_dot_reg)
                  && $stable(numeric_ok_reg))
        else $error("token state moved without a character");
`endif

endmodule

/* hw/rtl/literal_token_classifier_top.sv */
`timescale 1ns / 1ps

// Literal token classifier. Feed a token one character word per cycle on
// char_byte, marking its final character with last_char; on that final
// character one token_class word comes out (invalid, integer, float, double,
// boolean, string, struct literal or identifier), and no word for any other
// character. The block sustains one character per cycle unless a final character
// must wait for the output register: an input register takes each character, a
// single pass of flag logic in ltc_scan folds it into the running token state,
// and the class lands in an output register. With class_ready held low the
// output register holds its word; characters that are not final keep flowing,
// and a final character waits in the input register until the output word is
// taken.
module literal_token_classifier_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_byte,
    input  logic       last_char,
    input  logic       char_valid,
    output logic       char_ready,
    output logic [2:0] token_class,
    output logic       class_valid,
    input  logic       class_ready
);

    // input register
    logic                  in_valid_reg, in_valid_next;
    ltc_pkg::char_word_t   in_word_reg;

    // output register
    logic                  out_valid_reg, out_valid_next;
    ltc_pkg::token_class_t out_class_reg;

    ltc_pkg::token_class_t scan_class;
    logic                  advance;
    logic                  emit;

    // A held character moves on unless it is final and the output is full and not ready
    assign advance = in_valid_reg
                     && (!in_word_reg.last_char || !out_valid_reg || class_ready);
    assign emit    = advance && in_word_reg.last_char;

    assign char_ready = !in_valid_reg || advance;

    ltc_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .word        (in_word_reg),
        .token_class (scan_class)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (char_ready)
            in_valid_next = char_valid;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (class_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: input loads on handshake, output loads on emit, no reset
    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            in_word_reg.char_byte <= char_byte;
            in_word_reg.last_char <= last_char;
        end
        if (emit)
            out_class_reg <= scan_class;
    end

    assign class_valid = out_valid_reg;
    assign token_class = out_class_reg;

`ifndef NO_ASSERTIONS
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> class_valid)
        else $error("final character produced no class word");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        class_valid && !class_ready |-> !emit)
        else $error("pending class word overwritten");

    a_load_input: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_ready |=> in_valid_reg)
        else $error("accepted character not held");

    a_drain_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        class_valid && !class_ready |=> class_valid && $stable(token_class))
        else $error("class word dropped before it was taken");
`endif

endmodule

/* tb/tb_literal_token_classifier_top.sv */
`timescale 1ns / 1ps

module tb_literal_token_classifier_top;

    typedef logic [7:0] token_q_t[$];

    // Ceiling on the whole run, in clock cycles; far above the slowest correct run
    localparam int CYCLE_LIMIT  = 300000;
    // Cycles the receiver holds off during the pressure phase
    localparam int HOLD_CYCLES  = 300;
    // Longest idle gap the sender inserts before one character word
    localparam int MAX_GAP      = 20;
    // Extra cycles after the last class word, to watch for stray ones
    localparam int DRAIN_CYCLES = 8;

    // Running token state mirrored from the classifier, plus the class words
    // still owed by the block. Feed every accepted character word through
    // note_char; feed every accepted class word through check_class.
    class token_class_board;
        ltc_pkg::token_class_t expected_classes[$];
        int                    mismatches;

        logic [2:0]            pos;
        ltc_pkg::char_kind_t   lead_kind;
        logic                  dot_seen;
        logic                  num_ok;
        logic                  id_ok;
        logic                  true_ok;
        logic                  false_ok;
        string                 kw_true;
        string                 kw_false;

        function new();
            kw_true    = "true";
            kw_false   = "false";
            mismatches = 0;
            clear_token();
        endfunction

        function void clear_token();
            pos       = 3'd0;
            lead_kind = ltc_pkg::KIND_OTHER;
            dot_seen  = 1'b0;
            num_ok    = 1'b1;
            id_ok     = 1'b1;
            true_ok   = 1'b1;
            false_ok  = 1'b1;
        endfunction

        function bit digit_char(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit letter_char(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function ltc_pkg::char_kind_t lead_kind_of(logic [7:0] c);
            if (c == ltc_pkg::CH_QUOTE)
                return ltc_pkg::KIND_QUOTE;
            if (c == ltc_pkg::CH_LBRACE)
                return ltc_pkg::KIND_BRACE;
            if (c == ltc_pkg::CH_MINUS)
                return ltc_pkg::KIND_MINUS;
            if (letter_char(c) || c == ltc_pkg::CH_UNDERSCORE)
                return ltc_pkg::KIND_ALPHA;
            return ltc_pkg::KIND_OTHER;
        endfunction

        function void note_char(logic [7:0] c, logic last);
            logic                  first;
            logic                  num;
            logic                  dot;
            logic                  flt;
            logic                  id;
            logic                  tm;
            logic                  fm;
            ltc_pkg::char_kind_t   kind;
            ltc_pkg::token_class_t cls;

            first = (pos == 3'd0);
            kind  = first ? lead_kind_of(c) : lead_kind;

            // Number: skip a leading minus, allow one dot, allow f/F only as
            // the final character after a dot
            num = num_ok;
            dot = dot_seen;
            flt = 1'b0;
            if (!(first && c == ltc_pkg::CH_MINUS))
            begin
                if (c == ltc_pkg::CH_DOT)
                begin
                    if (dot)
                        num = 1'b0;
                    else
                        dot = 1'b1;
                end
                else if (!digit_char(c))
                begin
                    if (last && dot
                        && (c == ltc_pkg::CH_LOWER_F || c == ltc_pkg::CH_UPPER_F))
                        flt = 1'b1;
                    else
                        num = 1'b0;
                end
            end

            if (first)
                id = id_ok && (letter_char(c) || c == ltc_pkg::CH_UNDERSCORE);
            else
                id = id_ok && (letter_char(c) || digit_char(c)
                               || c == ltc_pkg::CH_UNDERSCORE);

            tm = true_ok && pos < 3'd4 && c == kw_true[pos];
            fm = false_ok && pos < 3'd5 && c == kw_false[pos];

            if (!last)
            begin
                pos       = (pos == ltc_pkg::POS_MAX) ? ltc_pkg::POS_MAX : pos + 3'd1;
                lead_kind = kind;
                dot_seen  = dot;
                num_ok    = num;
                id_ok     = id;
                true_ok   = tm;
                false_ok  = fm;
            end
            else
            begin
                if (pos != 3'd0 && kind == ltc_pkg::KIND_QUOTE && c == ltc_pkg::CH_QUOTE)
                    cls = ltc_pkg::CLS_STRING;
                else if ((tm && pos == ltc_pkg::TRUE_LAST_POS)
                         || (fm && pos == ltc_pkg::FALSE_LAST_POS))
                    cls = ltc_pkg::CLS_BOOL;
                else if (kind == ltc_pkg::KIND_BRACE)
                    cls = ltc_pkg::CLS_STRUCT;
                else if (num)
                    cls = !dot ? ltc_pkg::CLS_INT
                               : (flt ? ltc_pkg::CLS_FLOAT : ltc_pkg::CLS_DOUBLE);
                else if (id)
                    cls = ltc_pkg::CLS_IDENT;
                else
                    cls = ltc_pkg::CLS_INVALID;
                expected_classes.push_back(cls);
                clear_token();
            end
        endfunction

        function void check_class(logic [2:0] got);
            ltc_pkg::token_class_t want;

            if (expected_classes.size() == 0)
            begin
                $error("token_class: no class expected, actual %0d", got);
                mismatches++;
            end
            else
            begin
                want = expected_classes.pop_front();
                if (got !== want)
                begin
                    $error("token_class expected %0d actual %0d", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_classes.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic [7:0] char_byte;
    logic       last_char;
    logic       char_valid;
    logic       char_ready;
    logic [2:0] token_class;
    logic       class_valid;
    logic       class_ready = 1'b0;

    token_class_board sb;

    // Idle and stall rates of the current phase, in percent of cycles
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // Pressure hold-off: the main flow raises hold_req, the receiver owns the count
    logic hold_req    = 1'b0;
    logic hold_taken  = 1'b0;
    int   hold_left   = 0;
    int   cycle_count = 0;

    literal_token_classifier_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_byte   (char_byte),
        .last_char   (last_char),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .token_class (token_class),
        .class_valid (class_valid),
        .class_ready (class_ready)
    );

    always #6 clk = ~clk;

    // Watchdog: abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: stall at the phase rate, or hold off for a long stretch once
    // the pressure phase asks for it
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken  <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            class_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left   <= hold_left - 1;
            class_ready <= 1'b0;
        end
        else
        begin
            class_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: sample both handshakes on the edge, before any update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && char_ready)
                sb.note_char(char_byte, last_char);
            if (class_valid && class_ready)
                sb.check_class(token_class);
        end
    end

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1))
            return 8'("a" + $urandom_range(25));
        return 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(5))
            0, 1:    return rand_digit();
            2:       return ltc_pkg::CH_UNDERSCORE;
            default: return rand_letter();
        endcase
    endfunction

    function automatic token_q_t to_bytes(string s);
        token_q_t t;

        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        return t;
    endfunction

    // Build one random token; most are well-formed literals of some class with
    // random content, the rest near misses and noise
    function automatic token_q_t make_token();
        token_q_t t;
        string    w;
        string    punct;
        int       n;

        punct = "\"{-.fF_te0";
        case ($urandom_range(9))
            0:
            begin
                // string, sometimes left unterminated
                t.push_back(ltc_pkg::CH_QUOTE);
                n = $urandom_range(5);
                repeat (n) t.push_back(8'($urandom_range(8'h20, 8'h7E)));
                if ($urandom_range(4) != 0)
                    t.push_back(ltc_pkg::CH_QUOTE);
            end
            1:
            begin
                // keyword, exact or mutated
                w = $urandom_range(1) ? "true" : "false";
                t = to_bytes(w);
                case ($urandom_range(5))
                    0:       if (t.size() > 1) void'(t.pop_back());
                    1:       t.push_back(rand_word_char());
                    2:       t[$urandom_range(t.size() - 1)] = rand_letter();
                    default: ;
                endcase
            end
            2:
            begin
                t.push_back(ltc_pkg::CH_LBRACE);
                n = $urandom_range(4);
                repeat (n) t.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
            3, 4:
            begin
                // number: optional sign, digits, optional dot and fraction, suffix
                if ($urandom_range(2) == 0)
                    t.push_back(ltc_pkg::CH_MINUS);
                n = $urandom_range(4);
                repeat (n) t.push_back(rand_digit());
                if ($urandom_range(1))
                begin
                    t.push_back(ltc_pkg::CH_DOT);
                    n = $urandom_range(3);
                    repeat (n) t.push_back(rand_digit());
                    if ($urandom_range(2) == 0)
                        t.push_back($urandom_range(1) ? ltc_pkg::CH_LOWER_F
                                                      : ltc_pkg::CH_UPPER_F);
                end
                if (t.size() == 0)
                    t.push_back(rand_digit());
                // break the number now and then
                if ($urandom_range(6) == 0)
                    t.insert($urandom_range(t.size()), punct[$urandom_range(2, 5)]);
            end
            5, 6:
            begin
                t.push_back($urandom_range(7) == 0 ? ltc_pkg::CH_UNDERSCORE
                                                   : rand_letter());
                n = $urandom_range(7);
                repeat (n) t.push_back(rand_word_char());
                if ($urandom_range(9) == 0)
                    t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
            end
            7:
            begin
                // long token: drive the position count into saturation
                n = $urandom_range(8, 14);
                if ($urandom_range(1))
                begin
                    repeat (n) t.push_back(rand_digit());
                    if ($urandom_range(1))
                        t.insert($urandom_range(t.size()), ltc_pkg::CH_DOT);
                end
                else
                begin
                    t.push_back(rand_letter());
                    repeat (n) t.push_back(rand_word_char());
                end
            end
            8:
            begin
                n = $urandom_range(1, 6);
                repeat (n) t.push_back(8'($urandom_range(255)));
            end
            default:
            begin
                n = $urandom_range(1, 5);
                repeat (n) t.push_back(punct[$urandom_range(punct.len() - 1)]);
            end
        endcase
        return t;
    endfunction

    // Offer one character word; hold it until the block takes it. Valid is
    // left high on return so a back-to-back word needs no extra edge.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;

        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_byte  <= c;
        last_char  <= last;
        char_valid <= 1'b1;
        do
            @(posedge clk);
        while (!char_ready);
    endtask

    task automatic send_token(input token_q_t t);
        foreach (t[i])
            send_char(t[i], i == t.size() - 1);
    endtask

    // Run random tokens at one pair of idle and stall rates
    task automatic run_phase(input int idle_pct, input int stall_pct, input int char_budget);
        token_q_t t;
        int       sent;

        sender_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        sent = 0;
        while (sent < char_budget)
        begin
            t = make_token();
            send_token(t);
            sent += t.size();
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        char_byte   = 8'h00;
        last_char   = 1'b0;
        char_valid  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every class, lone minus, dot only, minus later, suffix
        // without a dot, empty string, lone quote, non-ASCII bytes
        recv_stall_pct <= 0;
        send_token(to_bytes("-"));
        send_token(to_bytes("."));
        send_token(to_bytes("-."));
        send_token(to_bytes(".f"));
        send_token(to_bytes("1-"));
        send_token(to_bytes("1f"));
        send_token(to_bytes("\"\""));
        send_token(to_bytes("\""));
        send_token(to_bytes("true"));
        send_token(to_bytes("{"));
        send_token(to_bytes("_"));
        send_token(to_bytes("9"));
        send_char(8'h80, 1'b1);
        send_char(8'hFF, 1'b1);

        // Pressure: the receiver holds off while the sender keeps offering
        hold_req <= 1'b1;
        run_phase(0, 0, 170);
        run_phase(68, 0, 160);
        run_phase(0, 68, 160);
        run_phase(7, 7, 160);
        run_phase(0, 0, 40);
        char_valid <= 1'b0;

        // Drain owed class words, then watch for stray ones
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
